/* src/dplt_pkg.sv */
package dplt_pkg;

  localparam int MaxLanesDefault = 4;
  localparam int TriesPerLevelDefault = 5;

  localparam int CfgIndexW = 2;
  localparam int CfgDataW = 8;

  localparam logic [CfgIndexW-1:0] CFG_LINK_RATE = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_ACTIVE_LANES = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_MAX_SWING = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_MAX_EMPHASIS = 2'd3;

  localparam logic [7:0] LINK_RATE_RESET = 8'h0A;
  localparam logic [2:0] ACTIVE_LANES_RESET = 3'd1;
  localparam logic [1:0] MAX_SWING_RESET = 2'd3;
  localparam logic [1:0] MAX_EMPHASIS_RESET = 2'd3;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CR = 2'd1;
  localparam logic [1:0] PH_EQ = 2'd2;

  localparam logic CMD_BEGIN = 1'b0;

  localparam logic [2:0] ACT_WAIT_SHORT = 3'd0;
  localparam logic [2:0] ACT_WAIT_LONG = 3'd1;
  localparam logic [2:0] ACT_TRAINED = 3'd2;
  localparam logic [2:0] ACT_FAILED = 3'd3;
  localparam logic [2:0] ACT_IGNORED = 3'd4;

  localparam int FLAG_CR_BIT = 0;
  localparam int FLAG_EQ_BIT = 1;
  localparam int FLAG_LOCK_BIT = 2;
  localparam int FLAG_ALIGN_BIT = 3;

  localparam logic [7:0] PAT_CR = 8'h21;
  localparam logic [7:0] PAT_EQ2 = 8'h22;
  localparam logic [7:0] PAT_EQ3 = 8'h23;
  localparam logic [7:0] RATE_5G4 = 8'h14;

  function automatic logic [5:0] lane_set_f(input logic [1:0] swing,
                                            input logic [1:0] emph,
                                            input logic [1:0] max_swing,
                                            input logic [1:0] max_emph);
    logic smax;
    logic emax;
    smax = (swing >= max_swing);
    emax = (emph >= max_emph);
    return {emax, emph, smax, swing};
  endfunction

endpackage

/* src/dp_link_training_controller.sv */
// An accepted word passes from the input register through the training logic into the result register.
// Throughput: one word per cycle; the input register holds one word while the
// result register waits, so the input stalls only when both are full.
// Reset (synchronous, rst_n low) returns training to idle, clears the levels and
// try count, restores the register defaults and drops any words in flight.
module dp_link_training_controller #(
  parameter int MAX_LANES = dplt_pkg::MaxLanesDefault,
  parameter int TRIES_PER_LEVEL = dplt_pkg::TriesPerLevelDefault
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dplt_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [dplt_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_command,
  input  logic [15:0]                    in_lane_status,
  input  logic [7:0]                     in_align_status,
  input  logic [1:0]                     in_request_swing,
  input  logic [1:0]                     in_request_emphasis,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_action,
  output logic [7:0]                     out_pattern_byte,
  output logic [5:0]                     out_lane_set_byte,
  output logic [3:0]                     out_link_flags
);
  import dplt_pkg::*;

  localparam logic [2:0] MaxLanesW = 3'(MAX_LANES);
  localparam logic [3:0] TriesW = 4'(TRIES_PER_LEVEL);

  logic [7:0] link_rate_r;
  logic [2:0] active_lanes_r;
  logic [1:0] max_swing_r;
  logic [1:0] max_emph_r;

  logic [1:0] phase_r, phase_nxt;
  logic [1:0] swing_r, swing_nxt;
  logic [1:0] emph_r, emph_nxt;
  logic [1:0] counted_r, counted_nxt;
  logic [2:0] tries_r, tries_nxt;
  logic       at_max_r, at_max_nxt;

  logic        s1_valid_r, s1_valid_nxt;
  logic        s1_command_r;
  logic [15:0] s1_lane_status_r;
  logic [7:0]  s1_align_r;
  logic [1:0]  s1_req_swing_r;
  logic [1:0]  s1_req_emph_r;

  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_action_r;
  logic [7:0] out_pattern_r;
  logic [5:0] out_lane_set_r;
  logic [3:0] out_flags_r;

  logic       out_free;
  logic       fire;
  logic [2:0] res_action;
  logic [7:0] res_pattern;
  logic [5:0] res_lane_set;
  logic [3:0] res_flags;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign fire = s1_valid_r && out_free;
  assign s1_valid_nxt = in_stall ? 1'b1 : in_valid;
  assign out_valid_nxt = fire ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_rate_r <= LINK_RATE_RESET;
      active_lanes_r <= ACTIVE_LANES_RESET;
      max_swing_r <= MAX_SWING_RESET;
      max_emph_r <= MAX_EMPHASIS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LINK_RATE: link_rate_r <= cfg_wdata;
        CFG_ACTIVE_LANES: active_lanes_r <= cfg_wdata[2:0];
        CFG_MAX_SWING: max_swing_r <= cfg_wdata[1:0];
        CFG_MAX_EMPHASIS: max_emph_r <= cfg_wdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [2:0] lanes_n;
    logic [2:0] acc;
    logic [7:0] eq_pat;
    logic [3:0] try_next;

    phase_nxt = phase_r;
    swing_nxt = swing_r;
    emph_nxt = emph_r;
    counted_nxt = counted_r;
    tries_nxt = tries_r;
    at_max_nxt = at_max_r;

    lanes_n = (active_lanes_r > MaxLanesW) ? MaxLanesW : active_lanes_r;
    acc = 3'b111;
    for (int i = 0; i < MAX_LANES; i++) begin
      if (3'(i) < lanes_n) begin
        acc = acc & s1_lane_status_r[4*i +: 3];
      end
    end
    if (lanes_n == 3'd0) begin
      acc = 3'b000;
    end
    res_flags = {s1_align_r[0], acc};
    eq_pat = (link_rate_r == RATE_5G4) ? PAT_EQ3 : PAT_EQ2;
    try_next = {1'b0, tries_r} + 4'd1;

    res_action = ACT_IGNORED;
    res_pattern = 8'd0;
    res_lane_set = 6'd0;

    if (s1_command_r == CMD_BEGIN) begin
      phase_nxt = PH_CR;
      swing_nxt = 2'd0;
      emph_nxt = 2'd0;
      counted_nxt = 2'd0;
      tries_nxt = 3'd0;
      res_lane_set = lane_set_f(2'd0, 2'd0, max_swing_r, max_emph_r);
      at_max_nxt = res_lane_set[2];
      res_action = ACT_WAIT_SHORT;
      res_pattern = PAT_CR;
      res_flags = 4'd0;
    end else if (phase_r != PH_CR && phase_r != PH_EQ) begin
      res_flags = 4'd0;
    end else if (phase_r == PH_CR && res_flags[FLAG_CR_BIT]) begin
      phase_nxt = PH_EQ;
      counted_nxt = swing_r;
      tries_nxt = 3'd0;
      res_lane_set = lane_set_f(swing_r, emph_r, max_swing_r, max_emph_r);
      at_max_nxt = res_lane_set[2];
      res_action = ACT_WAIT_LONG;
      res_pattern = eq_pat;
    end else if (phase_r == PH_EQ && !res_flags[FLAG_CR_BIT]) begin
      phase_nxt = PH_IDLE;
      res_action = ACT_FAILED;
    end else if (phase_r == PH_EQ && res_flags[FLAG_EQ_BIT] && res_flags[FLAG_LOCK_BIT]
                 && res_flags[FLAG_ALIGN_BIT]) begin
      phase_nxt = PH_IDLE;
      res_action = ACT_TRAINED;
    end else if (try_next >= TriesW || at_max_r) begin
      phase_nxt = PH_IDLE;
      res_action = ACT_FAILED;
    end else begin
      swing_nxt = s1_req_swing_r;
      emph_nxt = s1_req_emph_r;
      if (s1_req_swing_r != counted_r) begin
        counted_nxt = s1_req_swing_r;
        tries_nxt = 3'd0;
      end else begin
        tries_nxt = try_next[2:0];
      end
      res_lane_set = lane_set_f(s1_req_swing_r, s1_req_emph_r, max_swing_r, max_emph_r);
      at_max_nxt = res_lane_set[2];
      if (phase_r == PH_CR) begin
        res_action = ACT_WAIT_SHORT;
        res_pattern = PAT_CR;
      end else begin
        res_action = ACT_WAIT_LONG;
        res_pattern = eq_pat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      swing_r <= 2'd0;
      emph_r <= 2'd0;
      counted_r <= 2'd0;
      tries_r <= 3'd0;
      at_max_r <= 1'b0;
      s1_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (fire) begin
        phase_r <= phase_nxt;
        swing_r <= swing_nxt;
        emph_r <= emph_nxt;
        counted_r <= counted_nxt;
        tries_r <= tries_nxt;
        at_max_r <= at_max_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_command_r <= in_command;
      s1_lane_status_r <= in_lane_status;
      s1_align_r <= in_align_status;
      s1_req_swing_r <= in_request_swing;
      s1_req_emph_r <= in_request_emphasis;
    end
    if (fire) begin
      out_action_r <= res_action;
      out_pattern_r <= res_pattern;
      out_lane_set_r <= res_lane_set;
      out_flags_r <= res_flags;
    end
  end

  assign out_valid = out_valid_r;
  assign out_action = out_action_r;
  assign out_pattern_byte = out_pattern_r;
  assign out_lane_set_byte = out_lane_set_r;
  assign out_link_flags = out_flags_r;

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input register");

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && (res_action == ACT_FAILED || res_action == ACT_TRAINED))
    |=> phase_r == PH_IDLE)
    else $error("training did not return to idle after its final word");

  a_try_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tries_r < TriesW)
    else $error("try count beyond the per-level limit");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_action_r != ACT_WAIT_SHORT && out_action_r != ACT_WAIT_LONG)
    |-> (out_pattern_r == 8'd0 && out_lane_set_r == 6'd0))
    else $error("final or ignored result carries a pattern or lane setting");

endmodule
